### rtl/htd_pkg.sv
// ============================================================================
// htd_pkg
// Shared constants and types of the heat diffusion stencil block.
// ============================================================================
package htd_pkg;

    // Configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 15;

    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NEIGHBOR_GAIN = 2'd2;

    localparam int DIM_BITS  = 9;
    localparam int GAIN_BITS = 15;

    localparam logic [DIM_BITS-1:0]  GRID_WIDTH_RESET    = 9'd256;
    localparam logic [DIM_BITS-1:0]  GRID_HEIGHT_RESET   = 9'd256;
    localparam logic [GAIN_BITS-1:0] NEIGHBOR_GAIN_RESET = 15'd10486;

    localparam int MIN_DIM = 3;

    // Fixed point
    localparam int FRAC_BITS  = 16;
    localparam int GAIN_ONE   = 65536;
    localparam int ROUND_HALF = 32768;

    // Result coordinates
    localparam int COORD_BITS = 8;

    // Output queue
    localparam int QUEUE_DEPTH    = 8;
    localparam int QUEUE_PTR_BITS = 3;
    localparam int QUEUE_CNT_BITS = 4;

    typedef struct packed {
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic                  emit_up;
        logic                  emit_own;
        logic                  edge_node;
        logic                  last;
    } htd_tag_t;

endpackage

### rtl/htd_sample_if.sv
// ============================================================================
// htd_sample_if
// Input channel: one previous-time grid sample per transfer.
// ============================================================================
interface htd_sample_if #(
    parameter int SAMPLE_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] temp_in;

    modport source (output valid, output temp_in, input ready);
    modport sink   (input valid, input temp_in, output ready);
endinterface

### rtl/htd_result_if.sv
// ============================================================================
// htd_result_if
// Output channel: one updated grid node per transfer.
// ============================================================================
interface htd_result_if #(
    parameter int SAMPLE_BITS = 32
);
    import htd_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] temp_out;
    logic [COORD_BITS-1:0]         out_col;
    logic [COORD_BITS-1:0]         out_row;
    logic                          frame_last;

    modport source (output valid, output temp_out, output out_col, output out_row,
                    output frame_last, input ready);
    modport sink   (input valid, input temp_out, input out_col, input out_row,
                    input frame_last, output ready);
endinterface

### rtl/htd_ram.sv
// ============================================================================
// htd_ram
// Simple dual-port RAM, one write port, one registered read port.
// ============================================================================
module htd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### rtl/heat_diffusion_stencil_step.sv
// ============================================================================
// heat_diffusion_stencil_step
// One explicit Euler step of 2D heat diffusion, five-point stencil, over a
// raster stream of fixed-point temperatures held in three line buffers.
//
//   channel  dir  handshake        contents
//   sample   in   valid/ready      temp_in
//   result   out  valid/ready      temp_out, out_col, out_row, frame_last
//   cfg      in   cfg_we           cfg_index, cfg_data
//
// One sample per cycle while ready is high; a sample on the last row yields two
// results, so there the result port paces input.
// Sample to first result: buffer read, adder, multipliers, rounding.
// ready drops when the 8-entry output queue cannot absorb the results in flight.
// Reset clears counters and restores register defaults; line buffers are not
// cleared.
// ============================================================================
module heat_diffusion_stencil_step #(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [htd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [htd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    htd_sample_if.sink                         sample,
    htd_result_if.source                       result
);
    import htd_pkg::*;

    localparam int XB   = $clog2(MAX_WIDTH);
    localparam int YB   = $clog2(MAX_HEIGHT);
    localparam int WCW  = ($clog2(MAX_WIDTH + 1) > DIM_BITS) ? $clog2(MAX_WIDTH + 1) : DIM_BITS;
    localparam int HCW  = ($clog2(MAX_HEIGHT + 1) > DIM_BITS) ? $clog2(MAX_HEIGHT + 1) : DIM_BITS;
    localparam int SUMW = SAMPLE_BITS + 2;
    localparam int KW   = GAIN_BITS + 1;
    localparam int SW   = GAIN_BITS + 4;
    localparam int P1W  = SUMW + KW;
    localparam int P2W  = SAMPLE_BITS + SW;
    localparam int ACCW = SAMPLE_BITS + 20;
    localparam int RESW = ACCW - FRAC_BITS;
    localparam int TOTW = QUEUE_CNT_BITS + 1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] temp;
        logic [COORD_BITS-1:0]         col;
        logic [COORD_BITS-1:0]         row;
        logic                          last;
    } entry_t;

    // ---------------- configuration and counters ----------------
    logic [DIM_BITS-1:0]  width_reg, height_reg;
    logic [GAIN_BITS-1:0] gain_reg;
    logic [XB-1:0]        col_reg, col_inc;
    logic [YB-1:0]        row_reg;
    logic [WCW-1:0]       w_raw, w_eff, w_last;
    logic [HCW-1:0]       h_raw, h_eff, h_last;
    logic                 col_end, row_end;
    logic                 accept;
    logic                 in_ready;

    assign w_raw = WCW'(width_reg);
    assign h_raw = HCW'(height_reg);

    always_comb
    begin
        if (w_raw < WCW'(MIN_DIM))
            w_eff = WCW'(MIN_DIM);
        else if (w_raw > WCW'(MAX_WIDTH))
            w_eff = WCW'(MAX_WIDTH);
        else
            w_eff = w_raw;
        if (h_raw < HCW'(MIN_DIM))
            h_eff = HCW'(MIN_DIM);
        else if (h_raw > HCW'(MAX_HEIGHT))
            h_eff = HCW'(MAX_HEIGHT);
        else
            h_eff = h_raw;
    end

    assign w_last  = w_eff - WCW'(1);
    assign h_last  = h_eff - HCW'(1);
    assign col_end = (WCW'(col_reg) == w_last);
    assign row_end = (HCW'(row_reg) == h_last);
    assign col_inc = col_reg + XB'(1);
    assign accept  = sample.valid & in_ready;

    // ---------------- pipeline control ----------------
    logic     s1_valid_reg, s2_valid_reg, s3_valid_reg;
    htd_tag_t s1_tag_reg, s2_tag_reg, s3_tag_reg;
    htd_tag_t tag_next;

    always_comb
    begin
        tag_next.col       = COORD_BITS'(col_reg);
        tag_next.row       = COORD_BITS'(row_reg);
        tag_next.emit_up   = (row_reg != '0);
        tag_next.emit_own  = row_end;
        tag_next.edge_node = (col_reg == '0) || col_end || (row_reg == YB'(1));
        tag_next.last      = col_end;
    end

    // ---------------- output queue ----------------
    entry_t                    q_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wp_reg, rp_reg;
    logic [QUEUE_CNT_BITS-1:0] cnt_reg;
    logic [1:0]                push_cnt, n1, n2, n3;
    logic                      pop;
    logic [TOTW-1:0]           total;
    entry_t                    up_entry, own_entry, entry0, entry_h;

    assign n1 = s1_valid_reg ? (2'(s1_tag_reg.emit_up) + 2'(s1_tag_reg.emit_own)) : 2'd0;
    assign n2 = s2_valid_reg ? (2'(s2_tag_reg.emit_up) + 2'(s2_tag_reg.emit_own)) : 2'd0;
    assign n3 = s3_valid_reg ? (2'(s3_tag_reg.emit_up) + 2'(s3_tag_reg.emit_own)) : 2'd0;
    assign push_cnt = n3;
    assign total    = TOTW'(cnt_reg) + TOTW'(n1) + TOTW'(n2) + TOTW'(n3) + TOTW'(2);
    assign in_ready = (total <= TOTW'(QUEUE_DEPTH));
    assign pop      = result.valid & result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= GRID_WIDTH_RESET;
            height_reg   <= GRID_HEIGHT_RESET;
            gain_reg     <= NEIGHBOR_GAIN_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            wp_reg       <= '0;
            rp_reg       <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_GRID_WIDTH:
                    begin
                        width_reg <= cfg_data[DIM_BITS-1:0];
                        col_reg   <= '0;
                        row_reg   <= '0;
                    end
                    REG_GRID_HEIGHT:
                    begin
                        height_reg <= cfg_data[DIM_BITS-1:0];
                        col_reg    <= '0;
                        row_reg    <= '0;
                    end
                    REG_NEIGHBOR_GAIN:
                    begin
                        gain_reg <= cfg_data[GAIN_BITS-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (accept)
            begin
                if (col_end)
                begin
                    col_reg <= '0;
                    row_reg <= row_end ? '0 : row_reg + YB'(1);
                end
                else
                begin
                    col_reg <= col_inc;
                end
            end

            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;

            wp_reg  <= wp_reg + QUEUE_PTR_BITS'(push_cnt);
            rp_reg  <= rp_reg + QUEUE_PTR_BITS'(pop);
            cnt_reg <= cnt_reg + QUEUE_CNT_BITS'(push_cnt) - QUEUE_CNT_BITS'(pop);
        end
    end

    // ---------------- line buffers ----------------
    logic [XB-1:0]                 s1_x_reg;
    logic signed [SAMPLE_BITS-1:0] s1_s_reg;
    logic [SAMPLE_BITS-1:0]        above_c_raw, above_e_raw, two_n_raw;
    logic signed [SAMPLE_BITS-1:0] above_c, above_e, two_n;
    logic signed [SAMPLE_BITS-1:0] c_last_reg;

    htd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_above_c (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_x_reg),
        .wdata (s1_s_reg),
        .raddr (col_reg),
        .rdata (above_c_raw)
    );

    htd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_above_e (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_x_reg),
        .wdata (s1_s_reg),
        .raddr (col_inc),
        .rdata (above_e_raw)
    );

    htd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_two_above (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_x_reg),
        .wdata (above_c_raw),
        .raddr (col_reg),
        .rdata (two_n_raw)
    );

    assign above_c = $signed(above_c_raw);
    assign above_e = $signed(above_e_raw);
    assign two_n   = $signed(two_n_raw);

    // ---------------- datapath ----------------
    logic signed [SUMW-1:0]        sum_next, s2_sum_reg;
    logic signed [SAMPLE_BITS-1:0] s2_c_reg, s2_s_reg, s3_c_reg, s3_s_reg;
    logic signed [KW-1:0]          k_s;
    logic signed [SW-1:0]          self_w;
    logic signed [P1W-1:0]         p1_next, s3_p1_reg;
    logic signed [P2W-1:0]         p2_next, s3_p2_reg;
    logic signed [ACCW-1:0]        acc;
    logic signed [RESW-1:0]        rs;
    logic [RESW-SAMPLE_BITS:0]     rs_top;
    logic signed [SAMPLE_BITS-1:0] sat, t_up;

    // west neighbor is the centre of the previous sample on this row
    assign sum_next = SUMW'(two_n) + SUMW'(s1_s_reg) + SUMW'(above_e) + SUMW'(c_last_reg);

    assign k_s     = $signed({1'b0, gain_reg});
    assign self_w  = $signed(SW'(GAIN_ONE)) - $signed({2'b00, gain_reg, 2'b00});
    assign p1_next = k_s * s2_sum_reg;
    assign p2_next = self_w * s2_c_reg;

    assign acc    = ACCW'(s3_p1_reg) + ACCW'(s3_p2_reg) + ACCW'(ROUND_HALF);
    assign rs     = $signed(acc[ACCW-1:FRAC_BITS]);
    assign rs_top = rs[RESW-1:SAMPLE_BITS-1];

    always_comb
    begin
        if ((&rs_top) || !(|rs_top))
            sat = rs[SAMPLE_BITS-1:0];
        else if (rs[RESW-1])
            sat = $signed({1'b1, {(SAMPLE_BITS-1){1'b0}}});
        else
            sat = $signed({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    end

    assign t_up = s3_tag_reg.edge_node ? s3_c_reg : sat;

    always_comb
    begin
        up_entry.temp  = t_up;
        up_entry.col   = s3_tag_reg.col;
        up_entry.row   = s3_tag_reg.row - COORD_BITS'(1);
        up_entry.last  = 1'b0;
        own_entry.temp = s3_s_reg;
        own_entry.col  = s3_tag_reg.col;
        own_entry.row  = s3_tag_reg.row;
        own_entry.last = s3_tag_reg.last;
        entry0         = s3_tag_reg.emit_up ? up_entry : own_entry;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg   <= col_reg;
            s1_s_reg   <= sample.temp_in;
            s1_tag_reg <= tag_next;
        end
        if (s1_valid_reg)
        begin
            c_last_reg <= above_c;
        end
        s2_tag_reg <= s1_tag_reg;
        s2_sum_reg <= sum_next;
        s2_c_reg   <= above_c;
        s2_s_reg   <= s1_s_reg;
        s3_tag_reg <= s2_tag_reg;
        s3_p1_reg  <= p1_next;
        s3_p2_reg  <= p2_next;
        s3_c_reg   <= s2_c_reg;
        s3_s_reg   <= s2_s_reg;
        if (push_cnt != 2'd0)
        begin
            q_mem[wp_reg] <= entry0;
        end
        if (push_cnt == 2'd2)
        begin
            q_mem[wp_reg + QUEUE_PTR_BITS'(1)] <= own_entry;
        end
    end

    // ---------------- ports ----------------
    assign entry_h           = q_mem[rp_reg];
    assign sample.ready      = in_ready;
    assign result.valid      = (cnt_reg != '0);
    assign result.temp_out   = entry_h.temp;
    assign result.out_col    = entry_h.col;
    assign result.out_row    = entry_h.row;
    assign result.frame_last = entry_h.last;
endmodule
